// ===== hdl/ahd_pkg.sv =====
// Shared types, constants and helper functions for the Ascon-Hasha digest core.
// Depends on nothing. Used by ahd_round, ascon_hasha_digest_core and the testbench.
`timescale 1ns / 1ps

package ahd_pkg;

  typedef logic [63:0]      word_t;
  typedef word_t [4:0]      sponge_t;
  typedef logic [3:0]       rnd_idx_t;

  // Round index of the last round of every permutation.
  localparam rnd_idx_t RND_LAST = 4'd11;
  // Round count of the full permutation (initial value and final block).
  localparam int       ROUNDS_A = 12;

  // Round constant for round index 0 to 11.
  function automatic logic [7:0] round_const(input rnd_idx_t idx);
    logic [7:0] rc;
    unique case (idx)
      4'd0:    rc = 8'hf0;
      4'd1:    rc = 8'he1;
      4'd2:    rc = 8'hd2;
      4'd3:    rc = 8'hc3;
      4'd4:    rc = 8'hb4;
      4'd5:    rc = 8'ha5;
      4'd6:    rc = 8'h96;
      4'd7:    rc = 8'h87;
      4'd8:    rc = 8'h78;
      4'd9:    rc = 8'h69;
      4'd10:   rc = 8'h5a;
      4'd11:   rc = 8'h4b;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // Rotate a word right by a fixed amount between 1 and 63.
  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // Final block: keep the first count bytes, place 0x80 in the byte after them
  // and clear the rest. Byte 0 sits in bits 63..56.
  function automatic word_t pad_block(input word_t data, input logic [2:0] count);
    word_t res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < count) begin
        res[63-8*i -: 8] = data[63-8*i -: 8];
      end else if (3'(i) == count) begin
        res[63-8*i -: 8] = 8'h80;
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/ahd_round.sv =====
// One round of the Ascon v1.2 permutation, shared by every permutation step.
// Depends on ahd_pkg for the sponge type and the rotation helper.
`timescale 1ns / 1ps

module ahd_round (
  input  ahd_pkg::sponge_t st_in,
  input  logic [7:0]       rc,
  output ahd_pkg::sponge_t st_out
);
  import ahd_pkg::*;

  word_t x0, x1, x2, x3, x4;
  word_t t0, t1, t2, t3, t4;

  always_comb begin
    x0 = st_in[0];
    x1 = st_in[1];
    x2 = st_in[2];
    x3 = st_in[3];
    x4 = st_in[4];

    // Constant addition.
    x2 = x2 ^ {56'd0, rc};

    // Substitution layer, bit-sliced five-bit S-box.
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = ~x0 & x1;
    t1 = ~x1 & x2;
    t2 = ~x2 & x3;
    t3 = ~x3 & x4;
    t4 = ~x4 & x0;
    x0 = x0 ^ t1;
    x1 = x1 ^ t2;
    x2 = x2 ^ t3;
    x3 = x3 ^ t4;
    x4 = x4 ^ t0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;

    // Linear diffusion layer.
    st_out[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    st_out[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    st_out[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
    st_out[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    st_out[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
  end

endmodule

// ===== hdl/ascon_hasha_digest_core.sv =====
// Ascon-Hasha digest core: sequencer, sponge register and output register.
// Depends on ahd_pkg and the shared permutation round ahd_round.
`timescale 1ns / 1ps
//
//  Channel | Direction | tdata                                   | tlast
//  --------+-----------+-----------------------------------------+---------------
//  in_     | slave     | [63:0] block_data, [66:64] byte_count   | final_block
//  out_    | master    | [63:0] digest_word                      | last_word
//
//  One permutation round is done per cycle by the single round unit. A block
//  that is not final is absorbed and then runs the last ROUNDS_B rounds. A
//  final block is padded, absorbed and runs all 12 rounds; then each digest
//  word is loaded into the output register, with ROUNDS_B rounds before the
//  next one, and the initial value is rebuilt before in_tready rises again.
//  After reset the core first computes the initial value.
//  A digest word waiting in the output register stalls the sequencer only when
//  the next word is ready to be loaded.

module ascon_hasha_digest_core #(
  parameter int ROUNDS_B  = 8,
  parameter int OUT_WORDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] block_data, [66:64] byte_count, rest zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_word
  output logic        out_tlast
);
  import ahd_pkg::*;

  localparam int       WCW        = (OUT_WORDS > 1) ? $clog2(OUT_WORDS) : 1;
  localparam rnd_idx_t RND_FIRST_B = rnd_idx_t'(ROUNDS_A - ROUNDS_B);
  localparam logic [WCW-1:0] WORD_LAST = WCW'(OUT_WORDS - 1);
  localparam word_t    IV_WORD    = {16'h0040, 8'd12, 8'(ROUNDS_A - ROUNDS_B),
                                     32'(OUT_WORDS * 64)};

  localparam logic [1:0] S_IV   = 2'd0;
  localparam logic [1:0] S_PERM = 2'd1;
  localparam logic [1:0] S_IDLE = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]     state_r, state_nxt;
  rnd_idx_t       rnd_r, rnd_nxt;
  logic           squeeze_r, squeeze_nxt;
  logic [WCW-1:0] word_r, word_nxt;
  logic           out_valid_r, out_valid_nxt;
  sponge_t        sponge_r, sponge_nxt;
  word_t          out_data_r;
  logic           out_last_r;
  logic           out_load;
  sponge_t        round_out;
  logic           in_beat;

  // Shared permutation round.
  ahd_round u_round (
    .st_in  (sponge_r),
    .rc     (round_const(rnd_r)),
    .st_out (round_out)
  );

  assign in_beat    = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_load   = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Sequencer: initial value, absorb, permutation rounds and squeezing.
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    squeeze_nxt   = squeeze_r;
    word_nxt      = word_r;
    sponge_nxt    = sponge_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IV: begin
        sponge_nxt  = {64'd0, 64'd0, 64'd0, 64'd0, IV_WORD};
        rnd_nxt     = '0;
        squeeze_nxt = 1'b0;
        state_nxt   = S_PERM;
      end
      S_PERM: begin
        sponge_nxt = round_out;
        rnd_nxt    = rnd_r + 4'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = squeeze_r ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          if (in_tlast) begin
            sponge_nxt[0] = sponge_r[0] ^ pad_block(in_tdata[63:0], in_tdata[66:64]);
            rnd_nxt       = '0;
            squeeze_nxt   = 1'b1;
            word_nxt      = '0;
          end else begin
            sponge_nxt[0] = sponge_r[0] ^ in_tdata[63:0];
            rnd_nxt       = RND_FIRST_B;
            squeeze_nxt   = 1'b0;
          end
          state_nxt = S_PERM;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (word_r == WORD_LAST) begin
            state_nxt = S_IV;
          end else begin
            word_nxt  = word_r + 1'b1;
            rnd_nxt   = RND_FIRST_B;
            state_nxt = S_PERM;
          end
        end
      end
      default: state_nxt = S_IV;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IV;
      rnd_r       <= '0;
      squeeze_r   <= 1'b0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      squeeze_r   <= squeeze_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sponge and output payload registers; the sponge is rebuilt after reset.
  always_ff @(posedge clk) begin
    sponge_r <= sponge_nxt;
    if (out_load) begin
      out_data_r <= sponge_r[0];
      out_last_r <= (word_r == WORD_LAST);
    end
  end

`ifndef SYNTHESIS
  // Rounds never run past the last round constant.
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PERM |-> rnd_r <= RND_LAST)
    else $error("round index out of range");

  // A block that is not final starts a short permutation with no squeezing.
  a_absorb_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && !in_tlast |=> state_r == S_PERM && rnd_r == RND_FIRST_B && !squeeze_r)
    else $error("absorb did not start the short permutation");

  // The last digest word sends the sequencer back to rebuild the initial value.
  a_last_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && word_r == WORD_LAST |=> state_r == S_IV && out_tlast)
    else $error("last digest word not followed by reinitialisation");

  // A new output beat only appears when the sequencer was emitting.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_EMIT)
    else $error("output beat appeared outside the emit step");

  // No input is taken while a digest is still being squeezed.
  a_no_input_squeeze: assert property (@(posedge clk) disable iff (!rst_n)
    squeeze_r && state_r != S_IDLE |-> !in_tready)
    else $error("input accepted during squeezing");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench for the Ascon-Hasha digest core: directed and random messages
// checked beat by beat against a cycle-free sponge predictor.
// Depends on ahd_pkg (word and sponge types) and ascon_hasha_digest_core.
`timescale 1ns / 1ps

module testbench;
  import ahd_pkg::*;

  localparam int ROUNDS_B   = 8;
  localparam int OUT_WORDS  = 4;
  localparam int RAND_ITEMS = 140;
  localparam int STALL_MAX  = 2000;

  // One input beat of the message stream.
  typedef struct packed {
    logic [63:0] data;
    logic [2:0]  count;
    logic        fin;
  } msg_beat_t;

  // One digest beat that the core is due to produce.
  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } digest_beat_t;

  localparam logic [7:0] ROUND_KEY [12] = '{
    8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
  };

  // Directed messages: empty and short final blocks, masked tail bytes,
  // ignored byte counts on body blocks and back-to-back digests.
  localparam int N_DIRECTED = 19;
  localparam msg_beat_t DIRECTED [N_DIRECTED] = '{
    '{64'h0000_0000_0000_0000, 3'd0, 1'b1},
    '{64'hffff_ffff_ffff_ffff, 3'd7, 1'b1},
    '{64'hffff_ffff_ffff_ffff, 3'd0, 1'b1},
    '{64'h0123_4567_89ab_cdef, 3'd1, 1'b1},
    '{64'h0123_4567_89ab_cdef, 3'd2, 1'b1},
    '{64'h0123_4567_89ab_cdef, 3'd3, 1'b1},
    '{64'h0123_4567_89ab_cdef, 3'd4, 1'b1},
    '{64'h0123_4567_89ab_cdef, 3'd5, 1'b1},
    '{64'h0123_4567_89ab_cdef, 3'd6, 1'b1},
    '{64'h0000_0000_0000_0000, 3'd0, 1'b0},
    '{64'hffff_ffff_ffff_ffff, 3'd4, 1'b1},
    '{64'hffff_ffff_ffff_ffff, 3'd5, 1'b0},
    '{64'h8000_0000_0000_0001, 3'd7, 1'b0},
    '{64'h0000_0000_0000_0000, 3'd7, 1'b1},
    '{64'ha5a5_a5a5_a5a5_a5a5, 3'd3, 1'b0},
    '{64'h5a5a_5a5a_5a5a_5a5a, 3'd0, 1'b1},
    '{64'hfedc_ba98_7654_3210, 3'd3, 1'b1},
    '{64'h7fff_ffff_ffff_fffe, 3'd7, 1'b1},
    '{64'h8000_0000_0000_0000, 3'd1, 1'b1}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // [63:0] block_data, [66:64] byte_count, rest zero
  logic        in_tlast;   // final_block
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [63:0] digest_word
  logic        out_tlast;  // last_word

  sponge_t      sponge;
  digest_beat_t digest_due [$];
  int           fail_count;
  bit           calm;
  bit           random_phase;

  ascon_hasha_digest_core #(
    .ROUNDS_B  (ROUNDS_B),
    .OUT_WORDS (OUT_WORDS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic word_t ror64(input word_t v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // The last `rounds` rounds of the Ascon permutation.
  function automatic sponge_t sponge_rounds(input sponge_t s, input int rounds);
    word_t x0, x1, x2, x3, x4;
    word_t t0, t1, t2, t3, t4;
    x0 = s[0];
    x1 = s[1];
    x2 = s[2];
    x3 = s[3];
    x4 = s[4];
    for (int r = 12 - rounds; r < 12; r++) begin
      x2 ^= {56'd0, ROUND_KEY[r]};
      x0 ^= x4;
      x4 ^= x3;
      x2 ^= x1;
      t0 = ~x0 & x1;
      t1 = ~x1 & x2;
      t2 = ~x2 & x3;
      t3 = ~x3 & x4;
      t4 = ~x4 & x0;
      x0 ^= t1;
      x1 ^= t2;
      x2 ^= t3;
      x3 ^= t4;
      x4 ^= t0;
      x1 ^= x0;
      x0 ^= x4;
      x3 ^= x2;
      x2 = ~x2;
      x0 ^= ror64(x0, 19) ^ ror64(x0, 28);
      x1 ^= ror64(x1, 61) ^ ror64(x1, 39);
      x2 ^= ror64(x2, 1) ^ ror64(x2, 6);
      x3 ^= ror64(x3, 10) ^ ror64(x3, 17);
      x4 ^= ror64(x4, 7) ^ ror64(x4, 41);
    end
    return {x4, x3, x2, x1, x0};
  endfunction

  // Sponge state at the start of every message.
  function automatic sponge_t initial_sponge();
    sponge_t s;
    s    = '0;
    s[0] = (64'd64 << 48) | (64'd12 << 40) | (64'(12 - ROUNDS_B) << 32) |
           64'(OUT_WORDS * 64);
    return sponge_rounds(s, 12);
  endfunction

  // Absorb one accepted beat; a final beat queues the whole digest.
  task automatic absorb_beat(input word_t data, input logic [2:0] cnt, input logic fin);
    word_t        keep;
    digest_beat_t beat;
    if (!fin) begin
      sponge[0] ^= data;
      sponge = sponge_rounds(sponge, ROUNDS_B);
    end else begin
      keep = (cnt == 3'd0) ? '0 : ~({64{1'b1}} >> (8 * cnt));
      sponge[0] ^= (data & keep) ^ (64'h80 << (56 - 8 * cnt));
      sponge = sponge_rounds(sponge, 12);
      for (int k = 0; k < OUT_WORDS; k++) begin
        beat.word = sponge[0];
        beat.last = (k == OUT_WORDS - 1);
        digest_due.push_back(beat);
        if (k != OUT_WORDS - 1) begin
          sponge = sponge_rounds(sponge, ROUNDS_B);
        end
      end
      sponge = initial_sponge();
    end
  endtask

  // Offer one beat from a falling edge and hold it until it is taken.
  task automatic send_beat(input word_t data, input logic [2:0] cnt, input logic fin);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, cnt, data};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_beat(data, cnt, fin);
    @(negedge clk);
  endtask

  function automatic word_t random_word();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Result side: random back-pressure, a calm stretch and one long hold-off.
  initial begin : result_sink
    int cyc;
    cyc        = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (random_phase) cyc++;
      if (cyc >= 150 && cyc < 550) begin
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // Compare every digest beat with the oldest one due.
  always @(posedge clk) begin
    digest_beat_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_due.size() == 0) begin
        $error("unexpected digest beat: digest_word %h last_word %b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        due = digest_due.pop_front();
        if (out_tdata !== due.word) begin
          $error("digest_word: expected %h, actual %h", due.word, out_tdata);
          fail_count++;
        end
        if (out_tlast !== due.last) begin
          $error("last_word: expected %b, actual %b", due.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // End the run when neither channel moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Reset, directed table, random messages, then drain.
  initial begin : stimulus
    int          sent;
    int          n_body;
    msg_beat_t   row;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    fail_count   = 0;
    calm         = 1'b0;
    random_phase = 1'b0;
    sponge       = initial_sponge();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      send_beat(row.data, row.count, row.fin);
    end

    // Sender holds back until every digest so far has been drained.
    in_tvalid <= 1'b0;
    while (digest_due.size() != 0) @(negedge clk);

    // Random messages of zero to four body blocks and a final block.
    random_phase = 1'b1;
    sent         = 0;
    while (sent < RAND_ITEMS) begin
      calm   = (sent >= 60 && sent < 100);
      n_body = $urandom_range(4);
      for (int b = 0; b < n_body; b++) begin
        send_beat(random_word(), 3'($urandom_range(7)), 1'b0);
        sent++;
      end
      send_beat(random_word(), 3'($urandom_range(7)), 1'b1);
      sent++;
      if (sent >= 100 && sent < 106) begin
        in_tvalid <= 1'b0;
        while (digest_due.size() != 0) @(negedge clk);
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (digest_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
